@@ rtl/rtd_temperature_from_time_ratio_core_defines.svh @@
// Assertion macros for the RTL file that carries checks.
`ifndef RTD_TEMPERATURE_FROM_TIME_RATIO_CORE_DEFINES_SVH
`define RTD_TEMPERATURE_FROM_TIME_RATIO_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RTDTR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rtdtr assertion failed");
`define RTDTR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rtdtr assertion failed");
`else
`define RTDTR_ASSERT(lbl, clk, rstn, prop)
`define RTDTR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/rtdtr_pkg.sv @@
package rtdtr_pkg;

  localparam int RATIO_FRAC_BITS = 29;
  localparam int TEMP_FRAC_BITS  = 8;

  localparam int FIELD_W        = 16;
  localparam int TIME_W         = 2 * FIELD_W;
  localparam int TEMP_W         = 24;
  localparam int RATIO_INT_BITS = 4;
  localparam int Q_W            = RATIO_INT_BITS + RATIO_FRAC_BITS;
  localparam int KR_W           = 64;

  localparam logic [127:0] C0_X = ((128'd63944759600 << 33) / 128'd4851 + 128'd1) >> 1;
  localparam logic [127:0] KQ_X = ((128'd400000000 << 33) / 128'd231 + 128'd1) >> 1;
  localparam logic [127:0] AQ_X = ((128'd71060 << 17) / 128'd21 + 128'd1) >> 1;

  localparam logic [KR_W-1:0] C0    = C0_X[KR_W-1:0];
  localparam logic [63:0]     KQ    = KQ_X[63:0];
  localparam logic [31:0]     KQ_LO = KQ[31:0];
  localparam logic [31:0]     KQ_HI = KQ[63:32];

  localparam int C0_BITS = $clog2(C0_X + 128'd1);
  localparam int D_W     = C0_BITS + (C0_BITS % 2);
  localparam int S_W     = D_W / 2;
  localparam int T_W     = S_W + 2;

  localparam logic signed [T_W-1:0] AQ_S     = T_W'(AQ_X);
  localparam logic signed [T_W-1:0] LIMIT_S  = T_W'(200 << 16);
  localparam int                    RND_SH   = 16 - TEMP_FRAC_BITS;
  localparam int                    RND_HALF = (RND_SH > 0) ? (1 << (RND_SH - 1)) : 0;
  localparam int signed             T_MAX    = (1 << (TEMP_W - 1)) - 1;
  localparam int signed             T_MIN    = -(1 << (TEMP_W - 1));

  localparam logic [FIELD_W-1:0] MARKER = '1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_RTD_MARKER,
    ST_REF_MARKER,
    ST_ZERO_REF,
    ST_NO_ROOT
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } pipe_ctl_t;

endpackage

@@ rtl/rtdtr_if.sv @@
interface rtdtr_in_if;
  import rtdtr_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] rtd_time_int;
  logic [FIELD_W-1:0] rtd_time_frac;
  logic [FIELD_W-1:0] ref_time_int;
  logic [FIELD_W-1:0] ref_time_frac;
  modport source (output valid, rtd_time_int, rtd_time_frac, ref_time_int, ref_time_frac,
                  input ready);
  modport sink (input valid, rtd_time_int, rtd_time_frac, ref_time_int, ref_time_frac,
                output ready);
endinterface

interface rtdtr_out_if;
  import rtdtr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_q8;
  status_t                  status;
  logic                     second_root_used;
  modport source (output valid, temperature_q8, status, second_root_used, input ready);
  modport sink (input valid, temperature_q8, status, second_root_used, output ready);
endinterface

@@ rtl/rtd_temperature_from_time_ratio_core.sv @@
// Converts a pair of discharge times into an RTD temperature in degrees Celsius.
// The input channel carries one word per measurement: the RTD time and the
// reference time, each as 16-bit integer and fraction halves. The result channel
// returns one word per input word: a signed Q.8 temperature, a status code and a
// flag that tells when the second quadratic root was taken.
// From acceptance to the result becoming valid a word passes through one input
// stage, 33 stages of the ratio divider (one quotient bit each), two stages for
// the constant multiply and its sum, one for the discriminant, 28 stages of the
// square root (one result bit each) and one for root choice and rounding.
// Throughput is one word per cycle unless stalled; any valid/invalid mix flows.
// All stages advance together: when the output holds a word that is not taken,
// the whole pipeline and the input ready stop, and nothing is lost or repeated.
// Synchronous reset clears every valid bit, so no word leaves until new ones
// are accepted.
`include "rtd_temperature_from_time_ratio_core_defines.svh"

module rtd_temperature_from_time_ratio_core (
  input logic         clk,
  input logic         rst_n,
  rtdtr_in_if.sink    in_ch,
  rtdtr_out_if.source out_ch
);
  import rtdtr_pkg::*;

  logic en;

  logic [TIME_W-1:0] rtd_w;
  logic [TIME_W-1:0] ref_w;
  status_t           pre_status_nxt;
  pipe_ctl_t         pre_ctl_r;
  logic [TIME_W-1:0] pre_rtd_r;
  logic [TIME_W-1:0] pre_ref_r;

  pipe_ctl_t      div_ctl;
  logic [Q_W-1:0] quo;

  logic [Q_W+31:0] plo_nxt;
  logic [Q_W+31:0] phi_nxt;
  logic [Q_W+31:0] plo_r;
  logic [Q_W+31:0] phi_r;
  pipe_ctl_t       mul_ctl_r;

  logic [Q_W+63:0] prod;
  logic [KR_W-1:0] kr_r;
  pipe_ctl_t       kr_ctl_r;

  pipe_ctl_t      d_ctl_nxt;
  pipe_ctl_t      d_ctl_r;
  logic [D_W-1:0] d_r;

  pipe_ctl_t      sq_ctl;
  logic [S_W-1:0] root;

  logic signed [T_W-1:0]    t1;
  logic signed [T_W-1:0]    t2;
  logic                     use_first;
  logic signed [T_W-1:0]    chosen;
  logic signed [T_W:0]      rounded;
  logic signed [T_W:0]      scaled;
  logic signed [TEMP_W-1:0] temp_nxt;

  pipe_ctl_t                out_ctl_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic                     out_second_r;

  assign en          = !out_ctl_r.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign rtd_w = {in_ch.rtd_time_int, in_ch.rtd_time_frac};
  assign ref_w = {in_ch.ref_time_int, in_ch.ref_time_frac};

  always_comb begin
    if (in_ch.rtd_time_int == MARKER && in_ch.rtd_time_frac == MARKER) begin
      pre_status_nxt = ST_RTD_MARKER;
    end else if (in_ch.ref_time_int == MARKER && in_ch.ref_time_frac == MARKER) begin
      pre_status_nxt = ST_REF_MARKER;
    end else if (ref_w == '0) begin
      pre_status_nxt = ST_ZERO_REF;
    end else if ({{RATIO_INT_BITS{1'b0}}, rtd_w} >= {ref_w, {RATIO_INT_BITS{1'b0}}}) begin
      pre_status_nxt = ST_NO_ROOT;
    end else begin
      pre_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_ctl_r <= '0;
    end else if (en) begin
      pre_ctl_r <= '{valid: in_ch.valid, status: pre_status_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_rtd_r <= rtd_w;
      pre_ref_r <= ref_w;
    end
  end

  rtdtr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (pre_ctl_r),
    .num     (pre_rtd_r),
    .den     (pre_ref_r),
    .out_ctl (div_ctl),
    .quo     (quo)
  );

  assign plo_nxt = (Q_W + 32)'(quo) * (Q_W + 32)'(KQ_LO);
  assign phi_nxt = (Q_W + 32)'(quo) * (Q_W + 32)'(KQ_HI);

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
  end

  assign prod = {phi_r, 32'b0} + {32'b0, plo_r};

  always_ff @(posedge clk) begin
    if (en) begin
      kr_r <= KR_W'(prod >> RATIO_FRAC_BITS);
      d_r  <= D_W'(C0 - kr_r);
    end
  end

  always_comb begin
    d_ctl_nxt = kr_ctl_r;
    if (kr_ctl_r.status == ST_OK && kr_r > C0) begin
      d_ctl_nxt.status = ST_NO_ROOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ctl_r <= '0;
      kr_ctl_r  <= '0;
      d_ctl_r   <= '0;
    end else if (en) begin
      mul_ctl_r <= div_ctl;
      kr_ctl_r  <= mul_ctl_r;
      d_ctl_r   <= d_ctl_nxt;
    end
  end

  rtdtr_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (d_ctl_r),
    .rad     (d_r),
    .out_ctl (sq_ctl),
    .root    (root)
  );

  assign t1        = AQ_S - $signed({2'b0, root});
  assign t2        = AQ_S + $signed({2'b0, root});
  assign use_first = (t1 > 0) && (t1 < LIMIT_S);
  assign chosen    = use_first ? t1 : t2;
  assign rounded   = {chosen[T_W-1], chosen} + (T_W + 1)'(RND_HALF);
  assign scaled    = rounded >>> RND_SH;

  always_comb begin
    if (scaled > T_MAX) begin
      temp_nxt = TEMP_W'(T_MAX);
    end else if (scaled < T_MIN) begin
      temp_nxt = TEMP_W'(T_MIN);
    end else begin
      temp_nxt = TEMP_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else if (en) begin
      out_ctl_r <= sq_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp_r   <= (sq_ctl.status == ST_OK) ? temp_nxt : '0;
      out_second_r <= (sq_ctl.status == ST_OK) && !use_first;
    end
  end

  assign out_ch.valid            = out_ctl_r.valid;
  assign out_ch.temperature_q8   = out_temp_r;
  assign out_ch.status           = out_ctl_r.status;
  assign out_ch.second_root_used = out_second_r;

  `RTDTR_ASSERT(a_fault_zero, clk, rst_n, out_ch.valid && out_ch.status != ST_OK |-> out_ch.temperature_q8 == '0 && !out_ch.second_root_used)
  `RTDTR_ASSERT(a_first_root_range, clk, rst_n, out_ch.valid && out_ch.status == ST_OK && !out_ch.second_root_used |-> out_ch.temperature_q8 >= 0 && out_ch.temperature_q8 <= (200 << TEMP_FRAC_BITS))
  `RTDTR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_ch.valid && in_ch.ready)

endmodule

@@ rtl/rtdtr_div.sv @@
module rtdtr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  rtdtr_pkg::pipe_ctl_t          in_ctl,
  input  logic [rtdtr_pkg::TIME_W-1:0]  num,
  input  logic [rtdtr_pkg::TIME_W-1:0]  den,
  output rtdtr_pkg::pipe_ctl_t          out_ctl,
  output logic [rtdtr_pkg::Q_W-1:0]     quo
);
  import rtdtr_pkg::*;

  pipe_ctl_t         ctl_r [Q_W];
  logic [TIME_W-1:0] rem_r [Q_W];
  logic [TIME_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]    low_r [Q_W];
  logic [Q_W-1:0]    quo_r [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    pipe_ctl_t         ctl_in;
    logic [TIME_W-1:0] rem_in;
    logic [TIME_W-1:0] den_in;
    logic [Q_W-1:0]    low_in;
    logic [Q_W-1:0]    quo_in;
    logic [TIME_W:0]   trial;
    logic              fit;
    logic [TIME_W-1:0] rem_nxt;

    if (g == 0) begin : g_first
      assign ctl_in = in_ctl;
      assign rem_in = num >> RATIO_INT_BITS;
      assign den_in = den;
      assign low_in = {num[RATIO_INT_BITS-1:0], {RATIO_FRAC_BITS{1'b0}}};
      assign quo_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_r[g-1];
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign low_in = low_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    assign trial   = {rem_in, low_in[Q_W-1]};
    assign fit     = trial >= {1'b0, den_in};
    assign rem_nxt = fit ? TIME_W'(trial - {1'b0, den_in}) : trial[TIME_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (en) begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_in;
        low_r[g] <= low_in << 1;
        quo_r[g] <= {quo_in[Q_W-2:0], fit};
      end
    end
  end

  assign out_ctl = ctl_r[Q_W-1];
  assign quo     = quo_r[Q_W-1];

endmodule

@@ rtl/rtdtr_sqrt.sv @@
module rtdtr_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  rtdtr_pkg::pipe_ctl_t      in_ctl,
  input  logic [rtdtr_pkg::D_W-1:0] rad,
  output rtdtr_pkg::pipe_ctl_t      out_ctl,
  output logic [rtdtr_pkg::S_W-1:0] root
);
  import rtdtr_pkg::*;

  pipe_ctl_t      ctl_r [S_W];
  logic [D_W-1:0] v_r   [S_W];
  logic [D_W-1:0] res_r [S_W];

  for (genvar g = 0; g < S_W; g++) begin : g_stage
    localparam logic [D_W-1:0] BIT = D_W'(1) << (2 * (S_W - 1 - g));
    pipe_ctl_t      ctl_in;
    logic [D_W-1:0] v_in;
    logic [D_W-1:0] res_in;
    logic [D_W-1:0] trial;
    logic           fit;

    if (g == 0) begin : g_first
      assign ctl_in = in_ctl;
      assign v_in   = rad;
      assign res_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_r[g-1];
      assign v_in   = v_r[g-1];
      assign res_in = res_r[g-1];
    end

    assign trial = res_in + BIT;
    assign fit   = v_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else if (en) begin
        ctl_r[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[g]   <= fit ? v_in - trial : v_in;
        res_r[g] <= fit ? (res_in >> 1) + BIT : res_in >> 1;
      end
    end
  end

  assign out_ctl = ctl_r[S_W-1];
  assign root    = res_r[S_W-1][S_W-1:0];

endmodule
